[rtl/core/two_tone_sine_synth_voice_top_macros.svh]
// assertion macros for the two-tone sine voice
`ifndef TWO_TONE_SINE_SYNTH_VOICE_TOP_MACROS_SVH
`define TWO_TONE_SINE_SYNTH_VOICE_TOP_MACROS_SVH

// same-cycle implication
`define TTSSV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttssv check failed");

// next-cycle implication
`define TTSSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttssv check failed");

`endif

[rtl/core/ttssv_pkg.sv]
// package with types, constants and tables of the two-tone sine voice
package ttssv_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;

    localparam int REQ_W      = 2;
    localparam int PITCH_W    = 7;
    localparam int IN_DATA_W  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 17;
    localparam int STEP_A4_W  = 31;
    localparam int RATIO_W    = 17;
    localparam int PROD_W     = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_OSC1_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OSC2_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_A4_STEP   = 2'd2;

    localparam logic [GAIN_W-1:0]    OSC1_GAIN_RST = 17'd65536;
    localparam logic [GAIN_W-1:0]    OSC2_GAIN_RST = 17'd0;
    localparam logic [STEP_A4_W-1:0] A4_STEP_RST   = 31'd39370534;

    // pitch + NOTE_OFFSET keeps the note index non-negative, octave bias 10
    localparam int NOTE_OFFSET = 51;
    localparam int OCT_BIAS    = 10;
    localparam int RECIP_12    = 171;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic signed [15:0] LEVEL_ON = 16'sd19661;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NOTE_SET,
        ST_INNER,
        ST_MID,
        ST_SINE,
        ST_GAIN,
        ST_SUM,
        ST_LEVEL,
        ST_OUT
    } ttssv_state_t;

    typedef struct packed {
        logic note_mul;
        logic note_set;
        logic note_off;
        logic sin_start;
        logic sin_inner;
        logic sin_mid;
        logic sin_out;
        logic gain;
        logic sum;
        logic level;
        logic out_load;
    } ttssv_cmd_t;

    // 2^(s/12) in Q1.16
    function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [3:0] semi);
        logic [RATIO_W-1:0] r;
        case (semi)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/ttssv_datapath.sv]
// datapath: config registers, phase accumulators, sine polynomial and mixer
module ttssv_datapath
    import ttssv_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ttssv_cmd_t                 cmd,
    input  logic [PITCH_W-1:0]         pitch,
    input  logic                       cfg_we,
    input  logic [CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output logic signed [SAMPLE_W-1:0] sample
);

    localparam int LOW_BITS = SINE_ADDR_BITS - 2;
    localparam int U_SHIFT  = 16 - LOW_BITS;
    localparam int SH_BIAS  = PHASE_BITS - 32 - 16 - OCT_BIAS;

    logic [GAIN_W-1:0]    osc1_gain_reg;
    logic [GAIN_W-1:0]    osc2_gain_reg;
    logic [STEP_A4_W-1:0] a4_step_reg;

    logic [PHASE_BITS-1:0] phase_one_reg;
    logic [PHASE_BITS-1:0] phase_two_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic                  sounding_reg;

    logic [PROD_W-1:0] prod_reg;
    logic signed [7:0] shift_reg;

    logic [7:0]            note_n;
    logic [14:0]           note_scaled;
    logic [3:0]            note_oct;
    logic [3:0]            note_semi;
    logic signed [7:0]     shift_next;
    logic [7:0]            shift_mag;
    logic [PROD_W-1:0]     shifted;
    logic [PHASE_BITS-1:0] step_next;

    logic [PHASE_BITS-1:0]     lane_phase [2];
    logic [GAIN_W-1:0]         lane_gain  [2];
    logic [SINE_ADDR_BITS-1:0] addr_w     [2];
    logic [16:0]               u_raw_w    [2];
    logic [16:0]               u_w        [2];
    logic [33:0]               sq_w       [2];
    logic [29:0]               uc_w       [2];
    logic [31:0]               ui_w       [2];
    logic [33:0]               um_w       [2];
    logic [15:0]               half_w     [2];
    logic [14:0]               mag_w      [2];
    logic signed [33:0]        gp_w       [2];

    logic [16:0]        u_reg     [2];
    logic [16:0]        usq_reg   [2];
    logic [1:0]         quad_reg  [2];
    logic [15:0]        inner_reg [2];
    logic [16:0]        mid_reg   [2];
    logic signed [15:0] sine_reg  [2];
    logic signed [33:0] gp_reg    [2];

    logic signed [34:0] sum_reg;
    logic signed [50:0] lvl_reg;
    logic signed [15:0] level_sel;
    logic signed [18:0] y_w;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc1_gain_reg <= OSC1_GAIN_RST;
            osc2_gain_reg <= OSC2_GAIN_RST;
            a4_step_reg   <= A4_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_OSC1_GAIN: osc1_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_OSC2_GAIN: osc2_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_A4_STEP:   a4_step_reg   <= cfg_data[STEP_A4_W-1:0];
                default:       ;
            endcase
        end
    end

    // note on: octave and semitone split, ratio product, octave shift
    always_comb
    begin
        note_n      = 8'(pitch) + 8'(NOTE_OFFSET);
        note_scaled = 15'(note_n) * 15'(RECIP_12);
        note_oct    = note_scaled[14:11];
        note_semi   = 4'(note_n - 8'(note_oct) * 8'd12);
        shift_next  = $signed({4'b0000, note_oct}) + $signed(8'(SH_BIAS));
        if (shift_reg[7])
        begin
            shift_mag = 8'(-shift_reg);
            shifted   = prod_reg >> shift_mag;
        end
        else
        begin
            shift_mag = 8'(shift_reg);
            shifted   = prod_reg << shift_mag;
        end
        step_next = shifted[PHASE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.note_mul)
        begin
            prod_reg  <= PROD_W'(a4_step_reg) * PROD_W'(semitone_ratio(note_semi));
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_one_reg  <= '0;
            phase_two_reg  <= '0;
            phase_step_reg <= '0;
            sounding_reg   <= 1'b0;
        end
        else if (cmd.note_set)
        begin
            phase_one_reg  <= '0;
            phase_two_reg  <= '0;
            phase_step_reg <= step_next;
            sounding_reg   <= 1'b1;
        end
        else if (cmd.note_off)
        begin
            sounding_reg <= 1'b0;
        end
        else if (cmd.sin_start)
        begin
            phase_one_reg <= phase_one_reg + phase_step_reg;
            phase_two_reg <= phase_two_reg + {phase_step_reg[PHASE_BITS-2:0], 1'b0};
        end
    end

    assign lane_phase[0] = phase_one_reg;
    assign lane_phase[1] = phase_two_reg;
    assign lane_gain[0]  = osc1_gain_reg;
    assign lane_gain[1]  = osc2_gain_reg;

    // quarter-wave polynomial, one product per step
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            addr_w[i]  = lane_phase[i][PHASE_BITS-1 -: SINE_ADDR_BITS];
            u_raw_w[i] = 17'(addr_w[i][LOW_BITS-1:0]) << U_SHIFT;
            u_w[i]     = addr_w[i][LOW_BITS] ? (17'd65536 - u_raw_w[i]) : u_raw_w[i];
            sq_w[i]    = 34'(u_w[i]) * 34'(u_w[i]);
            uc_w[i]    = 30'(usq_reg[i]) * 30'(SIN_C);
            ui_w[i]    = 32'(usq_reg[i]) * 32'(inner_reg[i]);
            um_w[i]    = 34'(u_reg[i]) * 34'(mid_reg[i]);
            half_w[i]  = um_w[i][32:17];
            mag_w[i]   = half_w[i][15] ? 15'h7FFF : half_w[i][14:0];
            gp_w[i]    = $signed({1'b0, lane_gain[i]}) * sine_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.sin_start)
            begin
                u_reg[i]    <= u_w[i];
                usq_reg[i]  <= sq_w[i][32:16];
                quad_reg[i] <= {addr_w[i][SINE_ADDR_BITS-1], addr_w[i][LOW_BITS]};
            end
            if (cmd.sin_inner)
            begin
                inner_reg[i] <= SIN_B - {2'b00, uc_w[i][29:16]};
            end
            if (cmd.sin_mid)
            begin
                mid_reg[i] <= SIN_A - {1'b0, ui_w[i][31:16]};
            end
            if (cmd.sin_out)
            begin
                sine_reg[i] <= quad_reg[i][1] ? -$signed({1'b0, mag_w[i]})
                                              : $signed({1'b0, mag_w[i]});
            end
            if (cmd.gain)
            begin
                gp_reg[i] <= gp_w[i];
            end
        end
    end

    // level, floor of the 2^32 scaling, saturation
    always_comb
    begin
        level_sel = sounding_reg ? LEVEL_ON : 16'sd0;
        y_w       = lvl_reg[50:32];
        if (y_w > 19'sd32767)
        begin
            sample_next = 16'sh7FFF;
        end
        else if (y_w < -19'sd32768)
        begin
            sample_next = 16'sh8000;
        end
        else
        begin
            sample_next = y_w[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg <= {gp_reg[0][33], gp_reg[0]} + {gp_reg[1][33], gp_reg[1]};
        end
        if (cmd.level)
        begin
            lvl_reg <= sum_reg * level_sel;
        end
        if (cmd.out_load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

[rtl/core/ttssv_ctrl.sv]
// controller: sequencer state machine and stream handshakes
module ttssv_ctrl
    import ttssv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [REQ_W-1:0] req_type,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ttssv_cmd_t       cmd
);

    ttssv_state_t state_reg;
    ttssv_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (req_type)
                        REQ_TICK:
                        begin
                            cmd.sin_start = 1'b1;
                            state_next    = ST_INNER;
                        end
                        REQ_NOTE_ON:
                        begin
                            cmd.note_mul = 1'b1;
                            state_next   = ST_NOTE_SET;
                        end
                        REQ_NOTE_OFF:
                        begin
                            cmd.note_off = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NOTE_SET:
            begin
                cmd.note_set = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_INNER:
            begin
                cmd.sin_inner = 1'b1;
                state_next    = ST_MID;
            end
            ST_MID:
            begin
                cmd.sin_mid = 1'b1;
                state_next  = ST_SINE;
            end
            ST_SINE:
            begin
                cmd.sin_out = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while the previous beat is still held
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/core/two_tone_sine_synth_voice_top.sv]
// top level of the two-tone sine voice: controller, datapath and checks
//
//  port group   dir  width  beat contents
//  s_*          in   16     req_type, pitch
//  m_*          out  16     sample
//  cfg_*        in   31     osc1_gain, osc2_gain, a4_step by index
//
// a tick runs the inner, mid, sine, gain, sum, level and out states after acceptance,
// set by the dependent multiply chain of the sine polynomial; a note on runs the
// note set state and a note off none; input is taken again once the sequence ends.
// reset clears phases, step and level and loads the default gains and a4 step.
// one sample waits in the output register while the next beat is taken; a
// tick stalls in its last step until that sample is taken.
module two_tone_sine_synth_voice_top
    import ttssv_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] req_type, [8:2] pitch
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ttssv_cmd_t                 cmd;
    logic signed [SAMPLE_W-1:0] sample;

    ttssv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tdata[REQ_W-1:0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ttssv_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .pitch    (s_tdata[REQ_W +: PITCH_W]),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .sample   (sample)
    );

    assign m_tdata = sample;

`include "two_tone_sine_synth_voice_top_macros.svh"

    `TTSSV_ASSERT_NOW(a_no_overwrite, cmd.out_load, (!m_tvalid || m_tready))
    `TTSSV_ASSERT_NOW(a_busy_not_ready, (cmd.sin_inner || cmd.sin_mid || cmd.gain || cmd.level || cmd.note_set), !s_tready)
    `TTSSV_ASSERT_NEXT(a_tick_chain, cmd.sin_start, cmd.sin_inner)
    `TTSSV_ASSERT_NEXT(a_note_chain, cmd.note_mul, cmd.note_set)

endmodule

[tb/sv/two_tone_sine_synth_voice_top_test.sv]
// self-checking testbench of the two-tone sine voice with its own sample predictor
`timescale 1ns / 100ps

module two_tone_sine_synth_voice_top_test
    import ttssv_pkg::*;
;

    localparam logic [REQ_W-1:0]      REQ_UNUSED   = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED   = 2'd3;
    localparam longint                LEVEL_Q16    = 19661;
    localparam longint unsigned       POLY_A       = 102944;
    localparam longint unsigned       POLY_B       = 42048;
    localparam longint unsigned       POLY_C       = 4640;
    localparam int                    STALL_LIMIT  = 4000;
    localparam int                    SETTLE_TICKS = 16;

    typedef struct packed {
        logic [1:0] req;
        logic [6:0] pitch;
    } voice_beat_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // voice state as the block should hold it
    logic [16:0] gain_one;
    logic [16:0] gain_two;
    logic [30:0] a4_inc;
    logic [31:0] ph_one;
    logic [31:0] ph_two;
    logic [31:0] ph_inc;
    logic        voice_on;
    logic [16:0] ratio_q16 [0:11] = '{17'd65536, 17'd69433, 17'd73562, 17'd77936,
                                      17'd82570, 17'd87480, 17'd92682, 17'd98193,
                                      17'd104032, 17'd110218, 17'd116772, 17'd123715};

    voice_beat_t         note_beats [$];
    logic [SAMPLE_W-1:0] samples_due [$];
    voice_beat_t         next_beat;

    bit in_acc;
    bit out_acc;
    bit send_fast;
    int send_gap;
    int send_calm;
    int rcv_gap;
    int rcv_calm;
    int hold_req;
    int hold_left;
    int errors;
    int idle_cycles;
    logic [SAMPLE_W-1:0] want;

    two_tone_sine_synth_voice_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [1:0] req_type, [8:2] pitch
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] sample
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int sine_q15_of(input logic [31:0] ph);
        logic [9:0] addr;
        longint unsigned u, u2, inner, mid, s;
        addr = ph[31:22];
        u = longint'(addr[7:0]) << 8;
        if (addr[8])
            u = 65536 - u;
        u2 = (u * u) >> 16;
        inner = POLY_B - ((u2 * POLY_C) >> 16);
        mid = POLY_A - ((u2 * inner) >> 16);
        s = ((u * mid) >> 16) >> 1;
        if (s > 32767)
            s = 32767;
        return addr[9] ? -int'(s) : int'(s);
    endfunction

    function automatic logic [SAMPLE_W-1:0] mixed_sample();
        longint acc, y;
        acc = longint'(gain_one) * sine_q15_of(ph_one)
            + longint'(gain_two) * sine_q15_of(ph_two);
        acc = acc * (voice_on ? LEVEL_Q16 : 64'sd0);
        y = acc >>> 32;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return y[15:0];
    endfunction

    function automatic logic [31:0] note_step(input logic [6:0] p);
        int n, oct, sh;
        longint unsigned prod;
        n = int'(p) + 51;
        oct = n / 12 - 10;
        prod = longint'(a4_inc) * ratio_q16[n % 12];
        sh = oct - 16;
        if (sh >= 0)
            prod = prod << sh;
        else
            prod = prod >> (-sh);
        return prod[31:0];
    endfunction

    task automatic reset_voice();
        gain_one = 17'd65536;
        gain_two = 17'd0;
        a4_inc   = 31'd39370534;
        ph_one   = '0;
        ph_two   = '0;
        ph_inc   = '0;
        voice_on = 1'b0;
    endtask

    task automatic predict_beat(input logic [1:0] req, input logic [6:0] p);
        case (req)
            REQ_NOTE_ON:
            begin
                ph_inc   = note_step(p);
                ph_one   = '0;
                ph_two   = '0;
                voice_on = 1'b1;
            end
            REQ_NOTE_OFF:
                voice_on = 1'b0;
            REQ_TICK:
            begin
                samples_due.push_back(mixed_sample());
                ph_one = ph_one + ph_inc;
                ph_two = ph_two + (ph_inc << 1);
            end
            default: ;
        endcase
    endtask

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // prediction, sample check and watchdog
    always @(posedge clk)
    begin
        in_acc  = rst_n && s_tvalid && s_tready;
        out_acc = rst_n && m_tvalid && m_tready;
        if (!rst_n)
            reset_voice();
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_OSC1_GAIN: gain_one = cfg_data[16:0];
                CFG_OSC2_GAIN: gain_two = cfg_data[16:0];
                CFG_A4_STEP:   a4_inc   = cfg_data[30:0];
                default: ;
            endcase
        end
        if (in_acc)
            predict_beat(s_tdata[1:0], s_tdata[8:2]);
        if (out_acc)
        begin
            if (samples_due.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %0d",
                         $time, $signed(m_tdata));
                errors++;
            end
            else
            begin
                want = samples_due.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, $signed(want), $signed(m_tdata));
                    errors++;
                end
            end
        end
        if (in_acc || out_acc || cfg_we || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("two_tone_sine_synth_voice_top_test NOT OK");
            $finish;
        end
    end

    // input beat driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_acc))
        begin
            if (in_acc)
                send_gap = send_fast ? 0 : draw_gap(send_calm);
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (note_beats.size() > 0)
            begin
                next_beat = note_beats.pop_front();
                s_tdata  <= {7'd0, next_beat.pitch, next_beat.req};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sample receiver with per-beat gaps and a long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_acc)
                rcv_gap = draw_gap(rcv_calm);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_beat(input logic [1:0] req, input logic [6:0] p);
        voice_beat_t b;
        b.req   = req;
        b.pitch = p;
        note_beats.push_back(b);
    endtask

    task automatic push_ticks(input int count);
        int j;
        for (j = 0; j < count; j++)
            push_beat(REQ_TICK, 7'($urandom_range(0, 127)));
    endtask

    // mostly note on, a run of ticks, maybe a note off; some stray beats
    task automatic queue_phrases(input int count);
        int made, k;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    push_beat(REQ_NOTE_ON, 7'($urandom_range(0, 127)));
                    k = $urandom_range(1, 12);
                    push_ticks(k);
                    made += k + 1;
                    if ($urandom_range(0, 1))
                    begin
                        push_beat(REQ_NOTE_OFF, 7'($urandom_range(0, 127)));
                        k = $urandom_range(0, 3);
                        push_ticks(k);
                        made += k + 1;
                    end
                end
                7:
                    push_beat(REQ_UNUSED, 7'($urandom_range(0, 127)));
                8:
                begin
                    push_ticks(1);
                    made++;
                end
                default:
                begin
                    push_beat(REQ_NOTE_OFF, 7'($urandom_range(0, 127)));
                    made++;
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic wait_idle();
        while (note_beats.size() != 0 || s_tvalid || samples_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int ph;
        logic [CFG_DATA_W-1:0] g1, g2, a4;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // silent ticks, pitch extremes, stray request, note off
        push_beat(REQ_TICK, 7'd127);
        push_beat(REQ_TICK, 7'd0);
        push_beat(REQ_NOTE_ON, 7'd0);
        push_ticks(2);
        push_beat(REQ_NOTE_ON, 7'd127);
        push_ticks(3);
        push_beat(REQ_NOTE_ON, 7'd69);
        push_ticks(3);
        push_beat(REQ_UNUSED, 7'd127);
        push_ticks(1);
        push_beat(REQ_NOTE_OFF, 7'd85);
        push_ticks(2);
        push_beat(REQ_NOTE_ON, 7'd42);
        push_ticks(2);
        wait_idle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       begin g1 = 31'd65536;  g2 = 31'd65536;  a4 = 31'd39370534; end
                1:       begin g1 = 31'd0;      g2 = 31'd65536;  a4 = 31'h7FFFFFFF; end
                2:       begin g1 = 31'd131071; g2 = 31'd131071; a4 = 31'd39370534; end
                4:       begin g1 = 31'd0;      g2 = 31'd0;      a4 = 31'd1;        end
                default:
                begin
                    g1 = 31'($urandom_range(0, 131071));
                    g2 = 31'($urandom_range(0, 131071));
                    a4 = 31'($urandom);
                    if (a4 == 0)
                        a4 = 31'd1;
                end
            endcase
            write_reg(CFG_OSC1_GAIN, g1);
            write_reg(CFG_OSC2_GAIN, g2);
            write_reg(CFG_A4_STEP, a4);
            if (ph == 2)
                write_reg(CFG_UNUSED, 31'($urandom));
            if (ph == 1)
            begin
                // step wraps past the phase width
                push_beat(REQ_NOTE_ON, 7'd127);
                push_ticks(3);
            end
            if (ph == 3)
            begin
                send_fast = 1'b1;
                queue_phrases(200);
                hold_req = 300;
            end
            else
                queue_phrases(200);
            wait_idle();
            send_fast = 1'b0;
        end

        if (errors == 0)
            $display("two_tone_sine_synth_voice_top_test OK");
        else
            $display("two_tone_sine_synth_voice_top_test NOT OK");
        $finish;
    end

endmodule
